### hw/rtl/ied_pkg.sv
// Shared constants, types and helpers for the indel edit distance block.
// No dependencies; every other file except ied_ram imports this package.
package ied_pkg;

  localparam int MAX_LEN  = 64;
  localparam int CHAR_W   = 8;
  localparam int OPCODE_W = 2;
  localparam int DIST_W   = 8;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // costs reach at most 2*MAX_LEN
  localparam int COST_W   = $clog2(2 * MAX_LEN + 1);
  localparam int DIST_SAT = 255;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [COST_W-1:0]   cost_t;
  typedef logic [DIST_W-1:0]   dist_t;

  localparam opcode_t OP_LOAD_FIRST  = 2'd0;
  localparam opcode_t OP_LOAD_SECOND = 2'd1;
  localparam opcode_t OP_COMPUTE     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one wavefront slot handed from cell to cell
  typedef struct packed {
    logic  valid;
    logic  last;
    char_t ch;
    cost_t cur;   // D[i][j]
    cost_t prev;  // D[i][j-1]
  } wave_t;

  function automatic dist_t sat_dist(cost_t c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'(DIST_SAT)) ? dist_t'(DIST_SAT) : w[DIST_W-1:0];
  endfunction

endpackage

### hw/rtl/ied_if.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on ied_pkg for the field widths.
interface ied_in_if;
  import ied_pkg::*;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  char_t   char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface ied_out_if;
  import ied_pkg::*;
  logic  valid;
  logic  ready;
  dist_t distance;
  logic  overflowed;

  modport source (output valid, output distance, output overflowed, input ready);
  modport sink   (input valid, input distance, input overflowed, output ready);
endinterface

### hw/rtl/ied_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ied_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### hw/rtl/ied_cell.sv
// One column of the edit distance wavefront: holds a character of the first
// string and its running cost. Depends on ied_pkg.
module ied_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_en,
  input  ied_pkg::char_t load_char,
  input  logic          start,
  input  ied_pkg::cost_t init_cost,
  input  logic          active,
  input  ied_pkg::wave_t wave_in,
  output ied_pkg::wave_t wave_out
);
  import ied_pkg::*;

  char_t             char_r;
  cost_t             above_r;
  logic              valid_r;
  logic              last_r;
  char_t             ch_r;
  cost_t             cur_r;
  cost_t             prev_r;
  logic [COST_W:0]   left1;
  logic [COST_W:0]   up1;
  logic [COST_W:0]   diag2;
  logic [COST_W:0]   best;
  cost_t             val;

  always_comb begin
    left1 = {1'b0, wave_in.cur} + (COST_W+1)'(1);
    up1   = {1'b0, above_r} + (COST_W+1)'(1);
    diag2 = {1'b0, wave_in.prev} + (COST_W+1)'(2);
    best  = (left1 < up1) ? left1 : up1;
    best  = (diag2 < best) ? diag2 : best;
    if (char_r == wave_in.ch) begin
      val = wave_in.prev;
    end else begin
      val = best[COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= wave_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      char_r <= load_char;
    end
    if (start) begin
      above_r <= init_cost;
    end else if (wave_in.valid && active) begin
      above_r <= val;
    end
    last_r <= wave_in.last;
    ch_r   <= wave_in.ch;
    // columns past the first string's end pass the wavefront through
    if (active) begin
      cur_r  <= val;
      prev_r <= above_r;
    end else begin
      cur_r  <= wave_in.cur;
      prev_r <= wave_in.prev;
    end
  end

  assign wave_out = '{valid: valid_r, last: last_r, ch: ch_r, cur: cur_r, prev: prev_r};
endmodule

### hw/rtl/indel_edit_distance_top.sv
// Top level of the indel edit distance block: load control, second-string RAM,
// the chain of cost cells and the result register. Depends on ied_pkg, ied_if,
// ied_ram and ied_cell.
//
// Opcode 0 and 1 items append a byte to the first or second string; opcode 3
// is dropped. An opcode 2 item starts the computation: the second string is
// read from RAM one byte a cycle and streamed as a wavefront through a chain
// of MAX_LEN cells, each holding one byte of the first string and one column
// of costs. A compute item lasts until the last byte of the second string
// has left the end of the cell chain; with an empty second string it goes
// straight to the result. The input is held off until the result sits in the
// output register, which then waits for the sink while loading resumes. No
// reset sweep is needed.
module indel_edit_distance_top (
  input  logic      clk,
  input  logic      rst_n,
  ied_in_if.sink    in_ch,
  ied_out_if.source out_ch
);
  import ied_pkg::*;

  state_t state_r, state_nxt;
  len_t   first_len_r;
  len_t   second_len_r;
  logic   trunc_r;
  addr_t  j_r;
  logic   src_valid_r;
  logic   src_last_r;
  cost_t  src_j_r;
  cost_t  result_r;
  logic   out_valid_r;
  dist_t  out_distance_r;
  logic   out_overflowed_r;

  logic   in_ready;
  logic   in_acc;
  logic   start;
  logic   feed_en;
  logic   issue_last;
  logic   out_free;
  logic   out_load;
  logic   load_first;
  logic   load_second;
  char_t  ram_rdata;
  wave_t  wave [MAX_LEN+1];
  wave_t  tail;

  assign in_acc      = in_ch.valid && in_ready;
  assign load_first  = in_acc && (in_ch.opcode == OP_LOAD_FIRST) &&
                       (first_len_r < len_t'(MAX_LEN));
  assign load_second = in_acc && (in_ch.opcode == OP_LOAD_SECOND) &&
                       (second_len_r < len_t'(MAX_LEN));
  assign issue_last  = (len_t'(j_r) + len_t'(1)) == second_len_r;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign tail        = wave[MAX_LEN];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_COMPUTE)) begin
          state_nxt = (second_len_r == '0) ? ST_DONE : ST_FEED;
        end
      end
      ST_FEED: begin
        if (issue_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (tail.valid && tail.last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    feed_en  = 1'b0;
    start    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        start    = in_ch.valid && (in_ch.opcode == OP_COMPUTE);
      end
      ST_FEED:  feed_en  = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      trunc_r      <= 1'b0;
      j_r          <= '0;
      src_valid_r  <= 1'b0;
      src_last_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_valid_r <= feed_en;
      src_last_r  <= feed_en && issue_last;
      if (load_first)  first_len_r  <= first_len_r + len_t'(1);
      if (load_second) second_len_r <= second_len_r + len_t'(1);
      if (in_acc && !load_first && !load_second &&
          ((in_ch.opcode == OP_LOAD_FIRST) || (in_ch.opcode == OP_LOAD_SECOND))) begin
        trunc_r <= 1'b1;
      end
      if (start) begin
        j_r <= '0;
      end else if (feed_en) begin
        j_r <= j_r + addr_t'(1);
      end
      if (out_load) begin
        out_valid_r  <= 1'b1;
        first_len_r  <= '0;
        second_len_r <= '0;
        trunc_r      <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_j_r <= cost_t'(j_r) + cost_t'(1);
    if (start) begin
      result_r <= cost_t'(first_len_r);  // empty second string
    end else if (tail.valid && tail.last) begin
      result_r <= tail.cur;
    end
    if (out_load) begin
      out_distance_r   <= sat_dist(result_r);
      out_overflowed_r <= trunc_r;
    end
  end

  ied_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_second_ram (
    .clk   (clk),
    .we    (load_second),
    .waddr (second_len_r[ADDR_W-1:0]),
    .wdata (in_ch.char_code),
    .raddr (j_r),
    .rdata (ram_rdata)
  );

  // row zero of the cost matrix: D[0][j] = j
  assign wave[0] = '{valid: src_valid_r, last: src_last_r, ch: ram_rdata,
                     cur: src_j_r, prev: src_j_r - cost_t'(1)};

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    ied_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load_en   (load_first && (first_len_r == len_t'(k))),
      .load_char (in_ch.char_code),
      .start     (start),
      .init_cost (cost_t'(k + 1)),
      .active    (len_t'(k) < first_len_r),
      .wave_in   (wave[k]),
      .wave_out  (wave[k+1])
    );
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.distance   = out_distance_r;
  assign out_ch.overflowed = out_overflowed_r;
endmodule

### hw/rtl/ied_checker.sv
// Port-level assertions for the indel edit distance block, bound to the top.
// Depends on ied_pkg.
module ied_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input ied_pkg::opcode_t in_opcode,
  input logic            out_valid,
  input logic            out_ready,
  input ied_pkg::dist_t  out_distance,
  input logic            out_overflowed
);
  import ied_pkg::*;

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) &&
    $stable(out_overflowed))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // computation blocks the input for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_COMPUTE) |=> !in_ready)
    else $error("input taken while computing");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_distance) <= 2 * MAX_LEN))
    else $error("distance out of range");
endmodule

bind indel_edit_distance_top ied_checker u_ied_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_opcode      (in_ch.opcode),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_distance   (out_ch.distance),
  .out_overflowed (out_ch.overflowed)
);
